/* src/lom_pkg.sv */
package lom_pkg;

   localparam int IdWidth    = 20;
   localparam int QtyWidth   = 24;
   localparam int PriceWidth = 32;

   typedef enum logic [1:0] {
      ST_FILL    = 2'd0,
      ST_NONE    = 2'd1,
      ST_REST    = 2'd2,
      ST_DROPPED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_ROTATE,
      OP_DEC,
      OP_REMOVE,
      OP_APPEND
   } book_op_type;

   typedef struct packed {
      logic [IdWidth-1:0]    id;
      logic [QtyWidth-1:0]   qty;
      logic [PriceWidth-1:0] price;
   } entry_type;

   typedef struct packed {
      book_op_type         op;
      logic [QtyWidth-1:0] amt;
      entry_type           data;
   } book_cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MATCH,
      S_NEXT,
      S_SUMMARY
   } state_type;

endpackage

/* src/lom_if.sv */
interface lom_req_if;
   import lom_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  side;
   logic [IdWidth-1:0]    order_id;
   logic [PriceWidth-1:0] limit_price;
   logic [QtyWidth-1:0]   order_qty;
   modport source (output valid, side, order_id, limit_price, order_qty, input ready);
   modport sink (input valid, side, order_id, limit_price, order_qty, output ready);
endinterface

interface lom_rsp_if;
   import lom_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  is_fill;
   logic [IdWidth-1:0]    resting_id;
   logic [PriceWidth-1:0] fill_price;
   logic [QtyWidth-1:0]   fill_qty;
   logic [QtyWidth-1:0]   unfilled_qty;
   logic [1:0]            status;
   logic                  last;
   modport source (output valid, is_fill, resting_id, fill_price, fill_qty, unfilled_qty,
                   status, last, input ready);
   modport sink (input valid, is_fill, resting_id, fill_price, fill_qty, unfilled_qty,
                 status, last, output ready);
endinterface

/* src/lom_cell.sv */
module lom_cell
   import lom_pkg::*;
#(
   parameter int IDX = 0,
   parameter int IW  = 5,
   parameter int CW  = 6
) (
   input  logic         clock,
   input  book_cmd_type cmd,
   input  logic [IW-1:0] cmd_idx,
   input  logic [CW-1:0] count,
   input  entry_type    next_entry,
   input  entry_type    head_entry,
   output entry_type    entry
);

   entry_type entry_ff, entry_in;
   logic      at_idx, at_tail, below_tail, at_count, from_idx;

   assign at_idx     = (IW'(IDX) == cmd_idx);
   assign from_idx   = (IW'(IDX) >= cmd_idx);
   assign at_tail    = ((CW'(IDX) + CW'(1)) == count);
   assign below_tail = ((CW'(IDX) + CW'(1)) < count);
   assign at_count   = (CW'(IDX) == count);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         OP_ROTATE: begin
            if (at_tail) entry_in = head_entry;
            else if (below_tail) entry_in = next_entry;
         end
         OP_DEC: begin
            if (at_idx) entry_in.qty = entry_ff.qty - cmd.amt;
         end
         OP_REMOVE: begin
            if (from_idx) entry_in = next_entry;
         end
         OP_APPEND: begin
            if (at_count) entry_in = cmd.data;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* src/lom_book.sv */
module lom_book
   import lom_pkg::*;
#(
   parameter int BOOK_DEPTH = 32,
   parameter int IW         = 5,
   parameter int CW         = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  book_cmd_type  cmd,
   input  logic [IW-1:0] cmd_idx,
   output logic [CW-1:0] count,
   output entry_type     head
);

   entry_type         cells [BOOK_DEPTH];
   logic [CW-1:0]     count_ff, count_in;

   for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
      lom_cell #(.IDX(i), .IW(IW), .CW(CW)) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cmd_idx    (cmd_idx),
         .count      (count_ff),
         .next_entry ((i == BOOK_DEPTH - 1) ? cells[i] : cells[(i + 1) % BOOK_DEPTH]),
         .head_entry (cells[0]),
         .entry      (cells[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      case (cmd.op)
         OP_REMOVE: count_in = count_ff - CW'(1);
         OP_APPEND: count_in = count_ff + CW'(1);
         default:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;
   assign head  = cells[0];

endmodule

/* src/limit_order_matcher.sv */
// Price-time matcher over two books (bids, asks) of BOOK_DEPTH entries each, kept
// in arrival order in a row of cells. A search rotates the opposite book through
// its head cell one entry per cycle. Each fill takes a search over all N entries
// (N = entries in the opposite book), a match step and a step that readies the
// next search; a summary item closes the order. A stall on rsp holds the block in
// its match or summary step. Only one order is in work at a time: req.ready is
// high only while idle. Each order yields zero or more fill items, then one
// summary item with last set. A full own book drops the remainder (status 3).
module limit_order_matcher
   import lom_pkg::*;
#(
   parameter int BOOK_DEPTH = 32
) (
   input logic  clock,
   input logic  reset,
   lom_req_if.sink   req,
   lom_rsp_if.source rsp
);

   localparam int IW = $clog2(BOOK_DEPTH);
   localparam int CW = $clog2(BOOK_DEPTH + 1);

   state_type             state_ff, state_in;
   logic                  side_ff, side_in;
   logic [IdWidth-1:0]    id_ff, id_in;
   logic [PriceWidth-1:0] limit_ff, limit_in;
   logic [QtyWidth-1:0]   rem_ff, rem_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         best_idx_ff, best_idx_in;
   entry_type             best_ff, best_in;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_fill_ff, out_fill_in;
   logic [IdWidth-1:0]    out_id_ff, out_id_in;
   logic [PriceWidth-1:0] out_price_ff, out_price_in;
   logic [QtyWidth-1:0]   out_fq_ff, out_fq_in;
   logic [QtyWidth-1:0]   out_rem_ff, out_rem_in;
   status_type            out_st_ff, out_st_in;

   book_cmd_type  bid_cmd, ask_cmd, opp_cmd, own_cmd;
   logic [IW-1:0] opp_idx;
   logic [CW-1:0] bid_count, ask_count, opp_count, own_count;
   entry_type     bid_head, ask_head, opp_head;
   logic          out_free, crosses, better;
   logic [QtyWidth-1:0] mq;

   lom_book #(.BOOK_DEPTH(BOOK_DEPTH), .IW(IW), .CW(CW)) u_bids (
      .clock(clock), .reset(reset), .cmd(bid_cmd), .cmd_idx(opp_idx),
      .count(bid_count), .head(bid_head)
   );

   lom_book #(.BOOK_DEPTH(BOOK_DEPTH), .IW(IW), .CW(CW)) u_asks (
      .clock(clock), .reset(reset), .cmd(ask_cmd), .cmd_idx(opp_idx),
      .count(ask_count), .head(ask_head)
   );

   assign bid_cmd   = side_ff ? opp_cmd : own_cmd;
   assign ask_cmd   = side_ff ? own_cmd : opp_cmd;
   assign opp_count = side_ff ? bid_count : ask_count;
   assign own_count = side_ff ? ask_count : bid_count;
   assign opp_head  = side_ff ? bid_head : ask_head;
   assign opp_idx   = best_idx_ff;

   assign crosses  = side_ff ? (opp_head.price >= limit_ff) : (opp_head.price <= limit_ff);
   assign better   = side_ff ? (opp_head.price > best_ff.price)
                             : (opp_head.price < best_ff.price);
   assign mq       = (rem_ff < best_ff.qty) ? rem_ff : best_ff.qty;
   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      id_in        = id_ff;
      limit_in     = limit_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_fill_in  = out_fill_ff;
      out_id_in    = out_id_ff;
      out_price_in = out_price_ff;
      out_fq_in    = out_fq_ff;
      out_rem_in   = out_rem_ff;
      out_st_in    = out_st_ff;
      opp_cmd      = '{op: OP_NOP, amt: '0, data: '0};
      own_cmd      = '{op: OP_NOP, amt: '0, data: '0};
      req.ready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               side_in  = req.side;
               id_in    = req.order_id;
               limit_in = req.limit_price;
               rem_in   = req.order_qty;
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = (req.order_qty == '0) ? S_SUMMARY : S_SCAN;
            end
         end
         S_SCAN: begin
            if (cnt_ff == opp_count) begin
               state_in = found_ff ? S_MATCH : S_SUMMARY;
            end else begin
               if (crosses && (!found_ff || better)) begin
                  found_in    = 1'b1;
                  best_idx_in = cnt_ff[IW-1:0];
                  best_in     = opp_head;
               end
               opp_cmd.op = OP_ROTATE;
               cnt_in     = cnt_ff + CW'(1);
            end
         end
         S_MATCH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_fill_in  = 1'b1;
               out_id_in    = best_ff.id;
               out_price_in = best_ff.price;
               out_fq_in    = mq;
               out_rem_in   = rem_ff - mq;
               out_st_in    = ST_FILL;
               rem_in       = rem_ff - mq;
               opp_cmd.op   = (mq == best_ff.qty) ? OP_REMOVE : OP_DEC;
               opp_cmd.amt  = mq;
               state_in     = S_NEXT;
            end
         end
         S_NEXT: begin
            cnt_in   = '0;
            found_in = 1'b0;
            state_in = (rem_ff == '0) ? S_SUMMARY : S_SCAN;
         end
         S_SUMMARY: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_fill_in  = 1'b0;
               out_id_in    = '0;
               out_price_in = '0;
               out_fq_in    = '0;
               out_rem_in   = rem_ff;
               if (rem_ff == '0) begin
                  out_st_in = ST_NONE;
               end else if (own_count < CW'(BOOK_DEPTH)) begin
                  out_st_in    = ST_REST;
                  own_cmd.op   = OP_APPEND;
                  own_cmd.data = '{id: id_ff, qty: rem_ff, price: limit_ff};
               end else begin
                  out_st_in = ST_DROPPED;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff      <= side_in;
      id_ff        <= id_in;
      limit_ff     <= limit_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      found_ff     <= found_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      out_fill_ff  <= out_fill_in;
      out_id_ff    <= out_id_in;
      out_price_ff <= out_price_in;
      out_fq_ff    <= out_fq_in;
      out_rem_ff   <= out_rem_in;
      out_st_ff    <= out_st_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.is_fill      = out_fill_ff;
   assign rsp.resting_id   = out_id_ff;
   assign rsp.fill_price   = out_price_ff;
   assign rsp.fill_qty     = out_fq_ff;
   assign rsp.unfilled_qty = out_rem_ff;
   assign rsp.status       = out_st_ff;
   assign rsp.last         = !out_fill_ff;

endmodule

/* src/lom_checker.sv */
module lom_checker
   import lom_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_is_fill,
   input logic [QtyWidth-1:0] rsp_fill_qty,
   input logic [1:0]          rsp_status,
   input logic                rsp_last
);

   a_no_new_order: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("order accepted while another in work");

   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == !rsp_is_fill))
      else $error("last flag disagrees with record kind");

   a_fill_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_fill) |-> (rsp_status == ST_FILL && rsp_fill_qty != '0))
      else $error("bad fill item");

   a_summary_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_fill) |-> (rsp_status != ST_FILL && rsp_fill_qty == '0))
      else $error("bad summary item");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("item dropped while stalled");

endmodule

bind limit_order_matcher lom_checker u_lom_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_is_fill  (rsp.is_fill),
   .rsp_fill_qty (rsp.fill_qty),
   .rsp_status   (rsp.status),
   .rsp_last     (rsp.last)
);
